// ===== hdl/dream_flip_angle_map_top_macros.svh =====
// Assertion macros for the DREAM flip-angle map top level.
// Expects clk and rst_n in the scope of use; no other dependencies.
`ifndef DREAM_FLIP_ANGLE_MAP_TOP_MACROS_SVH
`define DREAM_FLIP_ANGLE_MAP_TOP_MACROS_SVH

// Check that a condition implies a consequence on the same edge.
`define DFAM_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition never holds.
`define DFAM_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ===== hdl/dfam_pkg.sv =====
// Shared types, constants and the CORDIC arctangent table for the flip-angle map.
// No dependencies.
`timescale 1ns / 1ps
package dfam_pkg;

    localparam int SAMPLE_BITS_DEFAULT     = 16;
    localparam int ANGLE_FRAC_BITS_DEFAULT = 8;
    localparam int Z_FRAC                  = 24;
    localparam int CORDIC_STEPS            = 28;
    localparam int Z_W                     = 34;
    localparam int XY_W                    = 36;
    localparam int REF_W                   = 7;
    localparam int CFG_IDX_W               = 1;
    localparam int CFG_DATA_W              = 7;
    localparam int QUEUE_DEPTH             = 4;

    localparam logic [CFG_IDX_W-1:0] REG_REFERENCE_ANGLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VOLUME_ORDER    = 1'd1;

    localparam logic [REF_W-1:0] REFERENCE_ANGLE_RESET = 7'd55;
    localparam logic             VOLUME_ORDER_RESET    = 1'b0;

    // 90 degrees with 24 fraction bits
    localparam logic signed [Z_W-1:0] Z_MAX = 34'sd1509949440;

    typedef struct packed {
        logic both_zero;
        logic p1_zero;
        logic p2_zero;
    } vox_class_t;

    // atan(2^-i) in degrees, 24 fraction bits
    function automatic logic signed [Z_W-1:0] atan_q24(input int unsigned i);
        logic signed [Z_W-1:0] r;
        case (i)
            0:       r = 34'sd754974720;
            1:       r = 34'sd445687602;
            2:       r = 34'sd235489088;
            3:       r = 34'sd119537938;
            4:       r = 34'sd60000934;
            5:       r = 34'sd30029717;
            6:       r = 34'sd15018523;
            7:       r = 34'sd7509720;
            8:       r = 34'sd3754917;
            9:       r = 34'sd1877466;
            10:      r = 34'sd938734;
            11:      r = 34'sd469367;
            12:      r = 34'sd234684;
            13:      r = 34'sd117342;
            14:      r = 34'sd58671;
            15:      r = 34'sd29335;
            16:      r = 34'sd14668;
            17:      r = 34'sd7334;
            18:      r = 34'sd3667;
            19:      r = 34'sd1833;
            20:      r = 34'sd917;
            21:      r = 34'sd458;
            22:      r = 34'sd229;
            23:      r = 34'sd115;
            24:      r = 34'sd57;
            25:      r = 34'sd29;
            26:      r = 34'sd14;
            27:      r = 34'sd7;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/dfam_front.sv =====
// Input stage: takes voxel items, orders numerator and denominator, classifies zeros.
// Depends on dfam_pkg.
`timescale 1ns / 1ps
module dfam_front
    import dfam_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   sample_valid,
    output logic                   sample_stall,
    input  logic [SAMPLE_BITS-1:0] sample_vol0,
    input  logic [SAMPLE_BITS-1:0] sample_vol1,
    input  logic                   volume_order,
    input  logic                   q_full,
    output logic                   q_push,
    output logic [SAMPLE_BITS-1:0] p1,
    output logic [SAMPLE_BITS-1:0] p2,
    output vox_class_t             cls
);

    logic                   vld_reg;
    logic [SAMPLE_BITS-1:0] p1_reg;
    logic [SAMPLE_BITS-1:0] p2_reg;
    vox_class_t             cls_reg;
    logic [SAMPLE_BITS-1:0] p1_next;
    logic [SAMPLE_BITS-1:0] p2_next;
    vox_class_t             cls_next;
    logic                   load;

    assign sample_stall = vld_reg && q_full;
    assign load         = !sample_stall;
    assign q_push       = vld_reg && !q_full;

    always_comb
    begin
        p1_next            = volume_order ? sample_vol1 : sample_vol0;
        p2_next            = volume_order ? sample_vol0 : sample_vol1;
        cls_next.p1_zero   = (p1_next == '0);
        cls_next.p2_zero   = (p2_next == '0);
        cls_next.both_zero = cls_next.p1_zero && cls_next.p2_zero;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (load)
        begin
            vld_reg <= sample_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && sample_valid)
        begin
            p1_reg  <= p1_next;
            p2_reg  <= p2_next;
            cls_reg <= cls_next;
        end
    end

    assign p1  = p1_reg;
    assign p2  = p2_reg;
    assign cls = cls_reg;

endmodule

// ===== hdl/dfam_queue.sv =====
// Short item queue between the input stage and the compute pipeline.
// Depends on dfam_pkg.
`timescale 1ns / 1ps
module dfam_queue
    import dfam_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic [SAMPLE_BITS-1:0] in_p1,
    input  logic [SAMPLE_BITS-1:0] in_p2,
    input  vox_class_t             in_cls,
    output logic                   full,
    input  logic                   pop,
    output logic                   empty,
    output logic [SAMPLE_BITS-1:0] out_p1,
    output logic [SAMPLE_BITS-1:0] out_p2,
    output vox_class_t             out_cls
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [SAMPLE_BITS-1:0] p1_mem [QUEUE_DEPTH];
    logic [SAMPLE_BITS-1:0] p2_mem [QUEUE_DEPTH];
    vox_class_t             cls_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;

    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            p1_mem[wr_ptr_reg]  <= in_p1;
            p2_mem[wr_ptr_reg]  <= in_p2;
            cls_mem[wr_ptr_reg] <= in_cls;
        end
    end

    assign out_p1  = p1_mem[rd_ptr_reg];
    assign out_p2  = p2_mem[rd_ptr_reg];
    assign out_cls = cls_mem[rd_ptr_reg];

endmodule

// ===== hdl/dfam_isqrt.sv =====
// Pipelined floor square root, one result bit per stage.
// Depends on dfam_pkg.
`timescale 1ns / 1ps
module dfam_isqrt
    import dfam_pkg::*;
#(
    parameter int RAD_W = 62
)
(
    input  logic                 clk,
    input  logic                 adv,
    input  logic [RAD_W-1:0]     radicand,
    output logic [RAD_W/2-1:0]   root
);

    localparam int STEPS = RAD_W / 2;

    logic [RAD_W-1:0] v_reg   [STEPS];
    logic [RAD_W-1:0] res_reg [STEPS];

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        localparam logic [RAD_W-1:0] BIT_K = {{(RAD_W-1){1'b0}}, 1'b1} << (RAD_W - 2 - 2 * k);
        logic [RAD_W-1:0] v_in;
        logic [RAD_W-1:0] res_in;
        logic [RAD_W-1:0] trial;
        logic [RAD_W-1:0] v_next;
        logic [RAD_W-1:0] res_next;

        if (k == 0)
        begin : g_first
            assign v_in   = radicand;
            assign res_in = '0;
        end
        else
        begin : g_rest
            assign v_in   = v_reg[k-1];
            assign res_in = res_reg[k-1];
        end

        always_comb
        begin
            trial = res_in + BIT_K;
            if (v_in >= trial)
            begin
                v_next   = v_in - trial;
                res_next = (res_in >> 1) + BIT_K;
            end
            else
            begin
                v_next   = v_in;
                res_next = res_in >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                v_reg[k]   <= v_next;
                res_reg[k] <= res_next;
            end
        end
    end

    assign root = res_reg[STEPS-1][RAD_W/2-1:0];

endmodule

// ===== hdl/dfam_back.sv =====
// Compute pipeline: square roots, CORDIC vectoring, rounding, ratio divider, output register.
// Depends on dfam_pkg and dfam_isqrt.
`timescale 1ns / 1ps
module dfam_back
    import dfam_pkg::*;
#(
    parameter int SAMPLE_BITS     = SAMPLE_BITS_DEFAULT,
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEFAULT
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_empty,
    output logic                         q_pop,
    input  logic [SAMPLE_BITS-1:0]       p1,
    input  logic [SAMPLE_BITS-1:0]       p2,
    input  vox_class_t                   cls,
    input  logic [REF_W-1:0]             reference_angle,
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic [7+ANGLE_FRAC_BITS-1:0] flip_angle,
    output logic [7+ANGLE_FRAC_BITS-1:0] b1_ratio,
    output logic                         undefined_flag
);

    localparam int OUT_W      = 7 + ANGLE_FRAC_BITS;
    localparam int SQRT_SHIFT = 2 * ((61 - SAMPLE_BITS) / 2);
    localparam int RAD_W      = 2 * ((SAMPLE_BITS + 2 + SQRT_SHIFT) / 2);
    localparam int RT_W       = RAD_W / 2;
    localparam int SQ         = RAD_W / 2;
    localparam int S          = Z_FRAC - ANGLE_FRAC_BITS;
    localparam int L          = SQ + CORDIC_STEPS + 1 + OUT_W + 1;
    localparam logic [OUT_W-1:0] ANGLE_MAX = OUT_W'(90) << ANGLE_FRAC_BITS;
    localparam logic [Z_W-1:0]   HALF_LSB  = {{(Z_W-1){1'b0}}, 1'b1} << (S - 1);

    logic           adv;
    logic [L-1:0]   vld_reg;
    logic [RAD_W-1:0] rad_x;
    logic [RAD_W-1:0] rad_y;
    logic [RT_W-1:0]  root_x;
    logic [RT_W-1:0]  root_y;

    assign adv          = !vld_reg[L-1] || !result_stall;
    assign q_pop        = adv && !q_empty;
    assign result_valid = vld_reg[L-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[L-2:0], q_pop};
        end
    end

    assign rad_y = {{(RAD_W-SAMPLE_BITS-1){1'b0}}, p1, 1'b0} << SQRT_SHIFT;
    assign rad_x = {{(RAD_W-SAMPLE_BITS){1'b0}}, p2} << SQRT_SHIFT;

    dfam_isqrt #(.RAD_W(RAD_W)) u_sqrt_x
    (
        .clk      (clk),
        .adv      (adv),
        .radicand (rad_x),
        .root     (root_x)
    );

    dfam_isqrt #(.RAD_W(RAD_W)) u_sqrt_y
    (
        .clk      (clk),
        .adv      (adv),
        .radicand (rad_y),
        .root     (root_y)
    );

    vox_class_t cls_d_reg [SQ];

    for (genvar k = 0; k < SQ; k++)
    begin : g_cls_delay
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                cls_d_reg[k] <= (k == 0) ? cls : cls_d_reg[(k == 0) ? 0 : k-1];
            end
        end
    end

    logic signed [XY_W-1:0] x_reg [CORDIC_STEPS];
    logic signed [XY_W-1:0] y_reg [CORDIC_STEPS];
    logic signed [Z_W-1:0]  z_reg [CORDIC_STEPS];
    vox_class_t             ccls_reg [CORDIC_STEPS];

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        logic signed [XY_W-1:0] x_in;
        logic signed [XY_W-1:0] y_in;
        logic signed [Z_W-1:0]  z_in;
        vox_class_t             c_in;
        logic signed [XY_W-1:0] dx;
        logic signed [XY_W-1:0] dy;
        logic signed [XY_W-1:0] x_next;
        logic signed [XY_W-1:0] y_next;
        logic signed [Z_W-1:0]  z_next;

        if (i == 0)
        begin : g_first
            assign x_in = $signed({{(XY_W-RT_W){1'b0}}, root_x});
            assign y_in = $signed({{(XY_W-RT_W){1'b0}}, root_y});
            assign z_in = '0;
            assign c_in = cls_d_reg[SQ-1];
        end
        else
        begin : g_rest
            assign x_in = x_reg[i-1];
            assign y_in = y_reg[i-1];
            assign z_in = z_reg[i-1];
            assign c_in = ccls_reg[i-1];
        end

        always_comb
        begin
            dx = y_in >>> i;
            dy = x_in >>> i;
            if (y_in > 0)
            begin
                x_next = x_in + dx;
                y_next = y_in - dy;
                z_next = z_in + atan_q24(i);
            end
            else
            begin
                x_next = x_in - dx;
                y_next = y_in + dy;
                z_next = z_in - atan_q24(i);
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                x_reg[i]    <= x_next;
                y_reg[i]    <= y_next;
                z_reg[i]    <= z_next;
                ccls_reg[i] <= c_in;
            end
        end
    end

    logic signed [Z_W-1:0] z_last;
    logic signed [Z_W-1:0] z_eff;
    logic [Z_W-1:0]        angle_sum;
    logic [Z_W-1:0]        num_sum;
    logic [OUT_W-1:0]      angle_next;
    logic [OUT_W-1:0]      rnd_angle_reg;
    logic [OUT_W-1:0]      rnd_num_reg;
    vox_class_t            rnd_cls_reg;
    vox_class_t            c_last;

    assign z_last = z_reg[CORDIC_STEPS-1];
    assign c_last = ccls_reg[CORDIC_STEPS-1];

    always_comb
    begin
        if (c_last.p1_zero)
        begin
            z_eff = '0;
        end
        else if (c_last.p2_zero)
        begin
            z_eff = Z_MAX;
        end
        else if (z_last < 0)
        begin
            z_eff = '0;
        end
        else if (z_last > Z_MAX)
        begin
            z_eff = Z_MAX;
        end
        else
        begin
            z_eff = z_last;
        end
        angle_sum  = $unsigned(z_eff) + HALF_LSB;
        num_sum    = $unsigned(z_eff) + ({{(Z_W-REF_W){1'b0}}, reference_angle} << (S - 1));
        angle_next = angle_sum[S +: OUT_W];
        if (angle_next > ANGLE_MAX)
        begin
            angle_next = ANGLE_MAX;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rnd_angle_reg <= angle_next;
            rnd_num_reg   <= num_sum[S +: OUT_W];
            rnd_cls_reg   <= c_last;
        end
    end

    logic [REF_W-1:0] rem_reg   [OUT_W];
    logic [OUT_W-1:0] num_reg   [OUT_W];
    logic [OUT_W-1:0] dangle_reg [OUT_W];
    vox_class_t       dcls_reg  [OUT_W];

    for (genvar j = 0; j < OUT_W; j++)
    begin : g_div
        logic [REF_W-1:0] rem_in;
        logic [OUT_W-1:0] num_in;
        logic [OUT_W-1:0] ang_in;
        vox_class_t       c_in;
        logic [REF_W:0]   part;
        logic [REF_W:0]   diff;
        logic             qbit;

        if (j == 0)
        begin : g_first
            assign rem_in = '0;
            assign num_in = rnd_num_reg;
            assign ang_in = rnd_angle_reg;
            assign c_in   = rnd_cls_reg;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[j-1];
            assign num_in = num_reg[j-1];
            assign ang_in = dangle_reg[j-1];
            assign c_in   = dcls_reg[j-1];
        end

        always_comb
        begin
            part = {rem_in, num_in[OUT_W-1]};
            diff = part - {1'b0, reference_angle};
            qbit = (part >= {1'b0, reference_angle});
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[j]    <= qbit ? diff[REF_W-1:0] : part[REF_W-1:0];
                num_reg[j]    <= {num_in[OUT_W-2:0], qbit};
                dangle_reg[j] <= ang_in;
                dcls_reg[j]   <= c_in;
            end
        end
    end

    logic [OUT_W-1:0] quot;
    vox_class_t       c_div;
    logic [OUT_W-1:0] flip_angle_reg;
    logic [OUT_W-1:0] b1_ratio_reg;
    logic             undefined_flag_reg;
    logic [OUT_W-1:0] flip_angle_next;
    logic [OUT_W-1:0] b1_ratio_next;

    assign quot  = num_reg[OUT_W-1];
    assign c_div = dcls_reg[OUT_W-1];

    always_comb
    begin
        flip_angle_next = dangle_reg[OUT_W-1];
        if (reference_angle == '0 || quot > ANGLE_MAX)
        begin
            b1_ratio_next = ANGLE_MAX;
        end
        else
        begin
            b1_ratio_next = quot;
        end
        if (c_div.both_zero)
        begin
            flip_angle_next = '0;
            b1_ratio_next   = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            flip_angle_reg     <= flip_angle_next;
            b1_ratio_reg       <= b1_ratio_next;
            undefined_flag_reg <= c_div.both_zero;
        end
    end

    assign flip_angle     = flip_angle_reg;
    assign b1_ratio       = b1_ratio_reg;
    assign undefined_flag = undefined_flag_reg;

endmodule

// ===== hdl/dream_flip_angle_map_top.sv =====
// Top level of the DREAM flip-angle map: config registers, input stage, queue, compute pipeline.
// Depends on dfam_pkg, dfam_front, dfam_queue, dfam_back and the assertion macro header.
//
//  channel   direction  handshake                    payload
//  sample    in         sample_valid / sample_stall  sample_vol0, sample_vol1
//  result    out        result_valid / result_stall  flip_angle, b1_ratio, undefined_flag
//  config    in         cfg_we                       cfg_index, cfg_data
//
// One item per cycle sustained while result_stall is low; from the accepting edge an item passes
// through the queue, square root, CORDIC, rounding, divider and output register stages.
// Reset clears the config registers to 55 degrees and volume order 0 and empties the pipeline.
// A stalled result holds the whole compute pipeline; the four-entry queue and input stage
// keep taking items until the queue fills.
`timescale 1ns / 1ps
`include "dream_flip_angle_map_top_macros.svh"
module dream_flip_angle_map_top
    import dfam_pkg::*;
#(
    parameter int SAMPLE_BITS     = SAMPLE_BITS_DEFAULT,
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEFAULT
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         sample_valid,
    output logic                         sample_stall,
    input  logic [SAMPLE_BITS-1:0]       sample_vol0,
    input  logic [SAMPLE_BITS-1:0]       sample_vol1,
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic [7+ANGLE_FRAC_BITS-1:0] flip_angle,
    output logic [7+ANGLE_FRAC_BITS-1:0] b1_ratio,
    output logic                         undefined_flag,
    input  logic                         cfg_we,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data
);

    localparam int OUT_W = 7 + ANGLE_FRAC_BITS;
    localparam logic [OUT_W-1:0] ANGLE_MAX = OUT_W'(90) << ANGLE_FRAC_BITS;

    logic [REF_W-1:0]       reference_angle_reg;
    logic                   volume_order_reg;
    logic                   q_full;
    logic                   q_push;
    logic                   q_empty;
    logic                   q_pop;
    logic [SAMPLE_BITS-1:0] f_p1;
    logic [SAMPLE_BITS-1:0] f_p2;
    vox_class_t             f_cls;
    logic [SAMPLE_BITS-1:0] h_p1;
    logic [SAMPLE_BITS-1:0] h_p2;
    vox_class_t             h_cls;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reference_angle_reg <= REFERENCE_ANGLE_RESET;
            volume_order_reg    <= VOLUME_ORDER_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_REFERENCE_ANGLE: reference_angle_reg <= cfg_data[REF_W-1:0];
                REG_VOLUME_ORDER:    volume_order_reg    <= cfg_data[0];
                default:             ;
            endcase
        end
    end

    dfam_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_vol0  (sample_vol0),
        .sample_vol1  (sample_vol1),
        .volume_order (volume_order_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .p1           (f_p1),
        .p2           (f_p2),
        .cls          (f_cls)
    );

    dfam_queue #(.SAMPLE_BITS(SAMPLE_BITS)) u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .in_p1   (f_p1),
        .in_p2   (f_p2),
        .in_cls  (f_cls),
        .full    (q_full),
        .pop     (q_pop),
        .empty   (q_empty),
        .out_p1  (h_p1),
        .out_p2  (h_p2),
        .out_cls (h_cls)
    );

    dfam_back #(.SAMPLE_BITS(SAMPLE_BITS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_empty         (q_empty),
        .q_pop           (q_pop),
        .p1              (h_p1),
        .p2              (h_p2),
        .cls             (h_cls),
        .reference_angle (reference_angle_reg),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .flip_angle      (flip_angle),
        .b1_ratio        (b1_ratio),
        .undefined_flag  (undefined_flag)
    );

    `DFAM_ASSERT_IMPLIES(a_undef_zero, result_valid && undefined_flag, flip_angle == '0 && b1_ratio == '0, "undefined item with nonzero result")
    `DFAM_ASSERT_IMPLIES(a_angle_range, result_valid, flip_angle <= ANGLE_MAX && b1_ratio <= ANGLE_MAX, "result above 90 degrees")
    `DFAM_ASSERT_NEVER(a_push_full, q_push && q_full, "push into full queue")
    `DFAM_ASSERT_NEVER(a_pop_empty, q_pop && q_empty, "pop from empty queue")

endmodule
